@@ rtl/core/ddt_pkg.sv @@
// Shared constants and types for the dataflow depth tracker.
package ddt_pkg;

	localparam int NUM_REGS   = 32;
	localparam int MAX_INSTS  = 65536;
	localparam int DEPTH_BITS = 24;

	localparam int REG_BITS = 5;
	localparam int IDX_BITS = 16;
	localparam int LAT_BITS = 8;
	localparam int WR_BITS  = IDX_BITS + 1;

	localparam int IN_FIELD_BITS  = 3 * REG_BITS + LAT_BITS;
	localparam int IN_DATA_W      = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = IDX_BITS + 2 * DEPTH_BITS + 2 * WR_BITS;
	localparam int OUT_DATA_W     = ((OUT_FIELD_BITS + 7) / 8) * 8;

	localparam logic [IDX_BITS-1:0]   LAST_INDEX = IDX_BITS'(MAX_INSTS - 1);
	localparam logic [WR_BITS-1:0]    NO_WRITER  = '1;
	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX  = '1;

	typedef struct packed {
		logic [IDX_BITS-1:0]   index;
		logic [DEPTH_BITS-1:0] finish;
	} entry_t;

	typedef struct packed {
		logic                en;
		logic [REG_BITS-1:0] addr;
		entry_t              data;
	} wr_t;

	typedef struct packed {
		logic [DEPTH_BITS-1:0] program_depth;
		logic [WR_BITS-1:0]    src2_writer;
		logic [WR_BITS-1:0]    src1_writer;
		logic [DEPTH_BITS-1:0] inst_depth;
		logic [IDX_BITS-1:0]   inst_index;
	} result_t;

endpackage

@@ rtl/core/ddt_table.sv @@
// Per-register writer table: two registered read ports, one write port, write forwarding.
module ddt_table import ddt_pkg::*; (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [REG_BITS-1:0] rd_addr1,
	input  logic [REG_BITS-1:0] rd_addr2,
	input  wr_t                 wr,
	output entry_t              rd_data1,
	output entry_t              rd_data2
);

	entry_t mem [NUM_REGS];
	entry_t rd_data1_q;
	entry_t rd_data2_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr1) begin
				rd_data1_q <= wr.data;
			end else begin
				rd_data1_q <= mem[rd_addr1];
			end
			if (wr.en && wr.addr == rd_addr2) begin
				rd_data2_q <= wr.data;
			end else begin
				rd_data2_q <= mem[rd_addr2];
			end
		end
	end

	assign rd_data1 = rd_data1_q;
	assign rd_data2 = rd_data2_q;

endmodule

@@ rtl/core/ddt_eval.sv @@
// Depth evaluation: valid bits, index counter, program depth and result forming.
module ddt_eval import ddt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  logic                start_req,
	input  logic [REG_BITS-1:0] dst_reg,
	input  logic [REG_BITS-1:0] src1_reg,
	input  logic [REG_BITS-1:0] src2_reg,
	input  logic [LAT_BITS-1:0] latency,
	input  entry_t              rd_data1,
	input  entry_t              rd_data2,
	output wr_t                 wr,
	output result_t             res
);

	logic [NUM_REGS-1:0]   valid_q;
	logic [IDX_BITS-1:0]   next_index_q;
	logic [DEPTH_BITS-1:0] max_finish_q;

	logic [NUM_REGS-1:0]   valid_cur;
	logic                  hit1;
	logic                  hit2;
	logic [DEPTH_BITS-1:0] fin1;
	logic [DEPTH_BITS-1:0] fin2;
	logic [DEPTH_BITS-1:0] depth;
	logic [DEPTH_BITS:0]   sum;
	logic [DEPTH_BITS-1:0] finish;
	logic [IDX_BITS-1:0]   idx;
	logic [DEPTH_BITS-1:0] max_base;
	logic [DEPTH_BITS-1:0] pmax;

	always_comb begin
		valid_cur = start_req ? '0 : valid_q;
		hit1      = valid_cur[src1_reg];
		hit2      = valid_cur[src2_reg];
		fin1      = hit1 ? rd_data1.finish : '0;
		fin2      = hit2 ? rd_data2.finish : '0;
		depth     = (fin1 > fin2) ? fin1 : fin2;
		sum       = {1'b0, depth} + (DEPTH_BITS + 1)'(latency);
		finish    = sum[DEPTH_BITS] ? DEPTH_MAX : sum[DEPTH_BITS-1:0];
		idx       = start_req ? '0 : next_index_q;
		max_base  = start_req ? '0 : max_finish_q;
		pmax      = (finish > max_base) ? finish : max_base;

		wr.en          = commit;
		wr.addr        = dst_reg;
		wr.data.index  = idx;
		wr.data.finish = finish;

		res.inst_index    = idx;
		res.inst_depth    = depth;
		res.src1_writer   = hit1 ? {1'b0, rd_data1.index} : NO_WRITER;
		res.src2_writer   = hit2 ? {1'b0, rd_data2.index} : NO_WRITER;
		res.program_depth = pmax;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			next_index_q <= '0;
			max_finish_q <= '0;
		end else if (commit) begin
			valid_q      <= valid_cur | (NUM_REGS'(1) << dst_reg);
			next_index_q <= (idx == LAST_INDEX) ? '0 : idx + 1'b1;
			max_finish_q <= pmax;
		end
	end

	a_start_index: assert property (@(posedge clk) disable iff (!arst_n)
		commit && start_req |=> next_index_q == IDX_BITS'(1))
		else $error("index not restarted by start");

	a_max_grows: assert property (@(posedge clk) disable iff (!arst_n)
		commit && !start_req |=> max_finish_q >= $past(max_finish_q))
		else $error("program depth decreased within a program");

	a_dst_valid: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> valid_q[$past(dst_reg)])
		else $error("destination not marked written");

	a_depth_order: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> res.program_depth >= res.inst_depth)
		else $error("program depth below instruction depth");

endmodule

@@ rtl/core/dataflow_depth_tracker.sv @@
// Dataflow depth tracker top level: input stage, table, evaluation and output register.
// Throughput: one instruction per cycle unless the output stalls.
// The table read is registered with write forwarding; m_axis_tvalid is the output register.
// Stalls on the output hold the input stage, which then deasserts s_axis_tready.
// Reset (arst_n low) clears valid bits, index counter, program depth and handshake state;
// the table contents are masked by valid bits, so no clearing pass follows reset.
module dataflow_depth_tracker import ddt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// dst_reg, src1_reg, src2_reg, latency, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// start_req
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// inst_index, inst_depth, src1_writer, src2_writer, program_depth, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic                valid_s1;
	logic                start_s1;
	logic [REG_BITS-1:0] dst_s1;
	logic [REG_BITS-1:0] src1_s1;
	logic [REG_BITS-1:0] src2_s1;
	logic [LAT_BITS-1:0] lat_s1;

	logic    out_valid_q;
	result_t out_res_q;

	logic    advance;
	logic    accept;
	entry_t  rd_data1;
	entry_t  rd_data2;
	wr_t     wr;
	result_t res;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_s1 <= s_axis_tuser;
			dst_s1   <= s_axis_tdata[REG_BITS-1:0];
			src1_s1  <= s_axis_tdata[2*REG_BITS-1:REG_BITS];
			src2_s1  <= s_axis_tdata[3*REG_BITS-1:2*REG_BITS];
			lat_s1   <= s_axis_tdata[IN_FIELD_BITS-1:3*REG_BITS];
		end
	end

	ddt_table u_table (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr1 (s_axis_tdata[2*REG_BITS-1:REG_BITS]),
		.rd_addr2 (s_axis_tdata[3*REG_BITS-1:2*REG_BITS]),
		.wr       (wr),
		.rd_data1 (rd_data1),
		.rd_data2 (rd_data2)
	);

	ddt_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (advance),
		.start_req (start_s1),
		.dst_reg   (dst_s1),
		.src1_reg  (src1_s1),
		.src2_reg  (src2_s1),
		.latency   (lat_s1),
		.rd_data1  (rd_data1),
		.rd_data2  (rd_data2),
		.wr        (wr),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_res_q);

endmodule

@@ verif/testbench.sv @@
// Self-checking stream testbench for the dataflow depth tracker.
module testbench import ddt_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHAIN_ITEMS  = 60;
	localparam int RANDOM_ITEMS = 560;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	logic                  reg_written [NUM_REGS];
	logic [IDX_BITS-1:0]   reg_writer  [NUM_REGS];
	logic [DEPTH_BITS-1:0] reg_finish  [NUM_REGS];
	logic [IDX_BITS-1:0]   inst_count;
	logic [DEPTH_BITS-1:0] critical_path;

	result_t pending_results [$];

	int tx_max_gap;
	int rx_max_gap;
	int rx_hold;
	int mismatches;
	int beats_sent;
	int beats_checked;
	int programs_started;
	int gap_sets [7][2] = '{'{0, 0}, '{18, 0}, '{0, 18}, '{18, 18}, '{3, 3}, '{18, 1}, '{1, 18}};

	dataflow_depth_tracker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic result_t schedule_instr(input logic start, input logic [REG_BITS-1:0] dst,
			input logic [REG_BITS-1:0] src1, input logic [REG_BITS-1:0] src2,
			input logic [LAT_BITS-1:0] lat);
		result_t             res;
		logic [DEPTH_BITS:0] sum;
		logic [DEPTH_BITS-1:0] finish;
		if (start) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				reg_written[r] = 1'b0;
			end
			inst_count = '0;
			critical_path = '0;
		end
		res.inst_index = inst_count;
		res.inst_depth = '0;
		res.src1_writer = NO_WRITER;
		res.src2_writer = NO_WRITER;
		if (reg_written[src1]) begin
			res.src1_writer = WR_BITS'(reg_writer[src1]);
			if (reg_finish[src1] > res.inst_depth)
				res.inst_depth = reg_finish[src1];
		end
		if (reg_written[src2]) begin
			res.src2_writer = WR_BITS'(reg_writer[src2]);
			if (reg_finish[src2] > res.inst_depth)
				res.inst_depth = reg_finish[src2];
		end
		sum = {1'b0, res.inst_depth} + (DEPTH_BITS + 1)'(lat);
		finish = sum[DEPTH_BITS] ? DEPTH_MAX : sum[DEPTH_BITS-1:0];
		reg_written[dst] = 1'b1;
		reg_writer[dst] = inst_count;
		reg_finish[dst] = finish;
		if (finish > critical_path)
			critical_path = finish;
		inst_count = (inst_count == LAST_INDEX) ? '0 : inst_count + 1'b1;
		res.program_depth = critical_path;
		return res;
	endfunction

	task automatic send_instr(input logic start, input logic [REG_BITS-1:0] dst,
			input logic [REG_BITS-1:0] src1, input logic [REG_BITS-1:0] src2,
			input logic [LAT_BITS-1:0] lat);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= start;
		s_axis_tdata <= IN_DATA_W'({lat, src2, src1, dst});
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(schedule_instr(start, dst, src1, src2, lat));
		beats_sent++;
		if (start)
			programs_started++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input longint unsigned exp_val,
			input longint unsigned act_val);
		if (exp_val != act_val) begin
			mismatches++;
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
		end
	endtask

	function automatic logic [REG_BITS-1:0] rand_reg();
		return $urandom_range(0, 1) ? REG_BITS'($urandom_range(0, 7))
			: REG_BITS'($urandom_range(0, NUM_REGS - 1));
	endfunction

	always @(posedge clk) begin
		result_t want;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[OUT_FIELD_BITS-1:0]);
			if (pending_results.size() == 0) begin
				mismatches++;
				$error("result beat with no instruction outstanding");
			end else begin
				want = pending_results.pop_front();
				beats_checked++;
				check_field("inst_index", want.inst_index, got.inst_index);
				check_field("inst_depth", want.inst_depth, got.inst_depth);
				check_field("src1_writer", want.src1_writer, got.src1_writer);
				check_field("src2_writer", want.src2_writer, got.src2_writer);
				check_field("program_depth", want.program_depth, got.program_depth);
			end
		end
	end

	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end else begin
				gap = $urandom_range(0, rx_max_gap);
			end
			@(negedge clk);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic test_directed();
		tx_max_gap = 5;
		rx_max_gap = 5;
		send_instr(1'b0, 5'd3, 5'd3, 5'd4, 8'd0);
		send_instr(1'b0, 5'd4, 5'd3, 5'd3, 8'd255);
		send_instr(1'b0, 5'd31, 5'd4, 5'd31, 8'd255);
		send_instr(1'b0, 5'd0, 5'd31, 5'd4, 8'd1);
		send_instr(1'b0, 5'd31, 5'd31, 5'd31, 8'd7);
		send_instr(1'b0, 5'd31, 5'd31, 5'd0, 8'd0);
		send_instr(1'b1, 5'd1, 5'd31, 5'd4, 8'd10);
		send_instr(1'b0, 5'd4, 5'd1, 5'd1, 8'd170);
		send_instr(1'b1, 5'd31, 5'd31, 5'd31, 8'd255);
		send_instr(1'b0, 5'd0, 5'd0, 5'd0, 8'd0);
		send_instr(1'b0, 5'd2, 5'd31, 5'd0, 8'd128);
		send_instr(1'b0, 5'd2, 5'd2, 5'd2, 8'd255);
		send_instr(1'b0, 5'd21, 5'd2, 5'd31, 8'd85);
		send_instr(1'b1, 5'd0, 5'd0, 5'd0, 8'd0);
		send_instr(1'b0, 5'd10, 5'd0, 5'd21, 8'd255);
		wait_drained();
	endtask

	task automatic test_long_chain();
		tx_max_gap = 0;
		rx_max_gap = 0;
		for (int i = 0; i < CHAIN_ITEMS; i++) begin
			send_instr(i == 0, 5'd0, 5'd0, REG_BITS'($urandom_range(0, NUM_REGS - 1)), 8'd255);
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		tx_max_gap = 0;
		rx_max_gap = 2;
		rx_hold = 120;
		for (int i = 0; i < 60; i++) begin
			send_instr(i == 0, rand_reg(), rand_reg(), rand_reg(), LAT_BITS'($urandom));
		end
		wait_drained();
	endtask

	task automatic test_random();
		logic [LAT_BITS-1:0] lat;
		for (int k = 0; k < 7; k++) begin
			tx_max_gap = gap_sets[k][0];
			rx_max_gap = gap_sets[k][1];
			for (int i = 0; i < RANDOM_ITEMS / 7; i++) begin
				if ($urandom_range(0, 3) == 0)
					lat = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				else
					lat = LAT_BITS'($urandom_range(0, 255));
				send_instr($urandom_range(0, 39) == 0, rand_reg(), rand_reg(), rand_reg(), lat);
			end
			if (k == 3)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = 1'b0;
		s_axis_tdata = '0;
		tx_max_gap = 0;
		rx_max_gap = 0;
		rx_hold = 0;
		mismatches = 0;
		beats_sent = 0;
		beats_checked = 0;
		programs_started = 0;
		for (int r = 0; r < NUM_REGS; r++) begin
			reg_written[r] = 1'b0;
			reg_writer[r] = '0;
			reg_finish[r] = '0;
		end
		inst_count = '0;
		critical_path = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_long_chain();
		test_backpressure();
		test_random();

		$display("Sent %0d instructions over %0d programs, checked %0d results.",
			beats_sent, programs_started, beats_checked);
		$display("Covered register reuse, program restarts, long dependency chains and output stalls.");
		if (mismatches == 0)
			$display("dataflow_depth_tracker: match");
		else
			$display("dataflow_depth_tracker: mismatch");
		$finish;
	end

	initial begin
		#8ms;
		$display("Timed out with %0d results outstanding.", pending_results.size());
		$display("dataflow_depth_tracker: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/ddt_pkg.sv
rtl/core/ddt_table.sv
rtl/core/ddt_eval.sv
rtl/core/dataflow_depth_tracker.sv
verif/testbench.sv
